// File: rtl/vpv_pkg.sv
// ----------------------------------------------------------------------------
// vpv_pkg
// shared types, constants and helpers of the vertex projection pipeline
// ----------------------------------------------------------------------------
package vpv_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DIV_STEPS     = 32;
    localparam int DIV_LAT       = DIV_STEPS + 2;
    localparam int ADDR_W        = 4;

    typedef enum logic [1:0] {
        REG_VP_X = 2'd0,
        REG_VP_Y = 2'd1,
        REG_VP_W = 2'd2,
        REG_VP_H = 2'd3
    } reg_idx_t;

    typedef enum logic {
        REQ_VERTEX = 1'b0,
        REQ_LOAD   = 1'b1
    } req_t;

    typedef struct packed {
        logic               valid;
        logic               wnull;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic signed [31:0] cw;
    } clip_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -64'sh0000_0000_8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// File: rtl/vertex_project_to_viewport_core.sv
// ----------------------------------------------------------------------------
// vertex_project_to_viewport_core
// object-space point to window coordinates through a 4x4 matrix
// ----------------------------------------------------------------------------
// One item is taken every cycle while out_ready keeps the output moving; a
// vertex result passes the input, product and sum stages, a 34-stage divider,
// half mapping, viewport product and output register. Coefficient loads give
// no result and land in the matrix as they leave the input stage, ahead of
// any later vertex. The whole pipeline stalls as one while a result waits.
// Viewport registers sit at byte addresses 0, 4, 8 and 12; the user must write
// them only while no vertex is in flight, and the block does not enforce this.
module vertex_project_to_viewport_core
    import vpv_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               req_type,
    input  logic [3:0]         coef_index,
    input  logic signed [31:0] coef_value,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] window_x,
    output logic signed [31:0] window_y,
    output logic signed [31:0] depth_z,
    output logic               w_was_null
);

    localparam logic signed [31:0] HALF = 32'sd1 <<< (FRAC_BITS - 1);

    logic signed [15:0] vp_x_reg;
    logic signed [15:0] vp_y_reg;
    logic [14:0]        vp_w_reg;
    logic [14:0]        vp_h_reg;

    logic  en;
    clip_t clip;
    logic signed [31:0] n_x, n_y, n_z;

    logic side_v_reg [DIV_LAT];
    logic side_n_reg [DIV_LAT];

    logic               v3_reg, n3_reg;
    logic signed [31:0] m_reg [3];
    logic               v4_reg, n4_reg;
    logic signed [47:0] px_reg, py_reg;
    logic signed [31:0] mz_reg;
    logic               v5_reg, n5_reg;
    logic signed [31:0] wx_reg, wy_reg, dz_reg;

    assign en       = !v5_reg || out_ready;
    assign in_ready = en;
    assign pready   = 1'b1;

    // configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_x_reg <= '0;
            vp_y_reg <= '0;
            vp_w_reg <= '0;
            vp_h_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            case (reg_idx_t'(paddr[3:2]))
                REG_VP_X: vp_x_reg <= pwdata[15:0];
                REG_VP_Y: vp_y_reg <= pwdata[15:0];
                REG_VP_W: vp_w_reg <= pwdata[14:0];
                REG_VP_H: vp_h_reg <= pwdata[14:0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx_t'(paddr[3:2]))
            REG_VP_X: prdata = 32'(vp_x_reg);
            REG_VP_Y: prdata = 32'(vp_y_reg);
            REG_VP_W: prdata = 32'(vp_w_reg);
            REG_VP_H: prdata = 32'(vp_h_reg);
            default:  prdata = '0;
        endcase
    end

    vpv_matrix_mult #(.FRAC_BITS(FRAC_BITS)) u_mult (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (in_valid),
        .req_type   (req_type),
        .coef_index (coef_index),
        .coef_value (coef_value),
        .point_x    (point_x),
        .point_y    (point_y),
        .point_z    (point_z),
        .clip       (clip)
    );

    vpv_divider #(.FRAC_BITS(FRAC_BITS)) u_div_x (
        .clk (clk), .en (en), .num (clip.cx), .den (clip.cw), .quot (n_x)
    );
    vpv_divider #(.FRAC_BITS(FRAC_BITS)) u_div_y (
        .clk (clk), .en (en), .num (clip.cy), .den (clip.cw), .quot (n_y)
    );
    vpv_divider #(.FRAC_BITS(FRAC_BITS)) u_div_z (
        .clk (clk), .en (en), .num (clip.cz), .den (clip.cw), .quot (n_z)
    );

    // valid and null flag alongside the dividers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_LAT; i++)
                side_v_reg[i] <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            side_v_reg[0] <= clip.valid;
            for (int i = 1; i < DIV_LAT; i++)
                side_v_reg[i] <= side_v_reg[i-1];
            v3_reg <= side_v_reg[DIV_LAT-1];
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_n_reg[0] <= clip.wnull;
            for (int i = 1; i < DIV_LAT; i++)
                side_n_reg[i] <= side_n_reg[i-1];
            n3_reg   <= side_n_reg[DIV_LAT-1];
            m_reg[0] <= (n_x >>> 1) + HALF;
            m_reg[1] <= (n_y >>> 1) + HALF;
            m_reg[2] <= (n_z >>> 1) + HALF;
            n4_reg   <= n3_reg;
            px_reg   <= 48'(m_reg[0]) * 48'($signed({1'b0, vp_w_reg}));
            py_reg   <= 48'(m_reg[1]) * 48'($signed({1'b0, vp_h_reg}));
            mz_reg   <= m_reg[2];
            n5_reg   <= n4_reg;
            wx_reg   <= sat32(64'(px_reg) + (64'(vp_x_reg) <<< FRAC_BITS));
            wy_reg   <= sat32(64'(py_reg) + (64'(vp_y_reg) <<< FRAC_BITS));
            dz_reg   <= mz_reg;
        end
    end

    assign out_valid  = v5_reg;
    assign window_x   = wx_reg;
    assign window_y   = wy_reg;
    assign depth_z    = dz_reg;
    assign w_was_null = n5_reg;

    // a vertex entering the product stage came from a vertex in the input stage
    a_vertex_only: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(u_mult.v1_reg) |-> $past(u_mult.v0_reg && (u_mult.type0_reg == REQ_VERTEX)))
        else $error("load item entered the product stage");

    // the divider side band keeps step with the pipeline under stall
    a_side_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(en) |-> ($stable(v3_reg) && $stable(v4_reg) && $stable(v5_reg)))
        else $error("pipeline valid moved during stall");

    // null w forces a unit divisor
    a_null_one: assert property (@(posedge clk) disable iff (!rst_n)
        (clip.valid && clip.wnull) |-> (clip.cw == (32'sd1 <<< FRAC_BITS)))
        else $error("null w not replaced by one");

endmodule

// File: rtl/vpv_matrix_mult.sv
// ----------------------------------------------------------------------------
// vpv_matrix_mult
// input stage, coefficient store and 4x4 matrix times point, three stages
// ----------------------------------------------------------------------------
module vpv_matrix_mult
    import vpv_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic               req_type,
    input  logic [3:0]         coef_index,
    input  logic signed [31:0] coef_value,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    output clip_t              clip
);

    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

    logic               v0_reg;
    logic               type0_reg;
    logic [3:0]         idx0_reg;
    logic signed [31:0] coef0_reg;
    logic signed [31:0] p_reg [3];
    logic signed [31:0] coef_reg [16];

    logic               v1_reg;
    logic signed [63:0] prod_reg [4][3];
    logic signed [63:0] prod_next [4][3];
    logic signed [31:0] bias_reg [4];

    clip_t clip_reg;
    clip_t clip_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            clip_reg <= '0;
            for (int i = 0; i < 16; i++)
                coef_reg[i] <= '0;
        end
        else if (en)
        begin
            v0_reg   <= in_valid;
            v1_reg   <= v0_reg && (req_t'(type0_reg) == REQ_VERTEX);
            clip_reg <= clip_next;
            // loads take effect as they leave the input stage, in item order
            if (v0_reg && (req_t'(type0_reg) == REQ_LOAD))
                coef_reg[idx0_reg] <= coef0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            type0_reg <= req_type;
            idx0_reg  <= coef_index;
            coef0_reg <= coef_value;
            p_reg[0]  <= point_x;
            p_reg[1]  <= point_y;
            p_reg[2]  <= point_z;
            for (int r = 0; r < 4; r++)
            begin
                bias_reg[r] <= coef_reg[r*4+3];
                for (int c = 0; c < 3; c++)
                    prod_reg[r][c] <= prod_next[r][c];
            end
        end
    end

    always_comb
    begin
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 3; c++)
                prod_next[r][c] = 64'(coef_reg[r*4+c]) * 64'(p_reg[c]);
    end

    always_comb
    begin
        logic signed [63:0] acc [4];
        logic signed [31:0] cl [4];
        for (int r = 0; r < 4; r++)
        begin
            acc[r] = 64'(bias_reg[r]);
            for (int c = 0; c < 3; c++)
                acc[r] = acc[r] + (prod_reg[r][c] >>> FRAC_BITS);
            cl[r] = sat32(acc[r]);
        end
        clip_next.valid = v1_reg;
        clip_next.wnull = (cl[3] == 32'sd0);
        clip_next.cx    = cl[0];
        clip_next.cy    = cl[1];
        clip_next.cz    = cl[2];
        clip_next.cw    = (cl[3] == 32'sd0) ? ONE : cl[3];
    end

    assign clip = clip_reg;

endmodule

// File: rtl/vpv_divider.sv
// ----------------------------------------------------------------------------
// vpv_divider
// pipelined restoring divider, one quotient bit per stage, saturated result
// ----------------------------------------------------------------------------
module vpv_divider
    import vpv_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] num,
    input  logic signed [31:0] den,
    output logic signed [31:0] quot
);

    localparam int DW = 32 + FRAC_BITS;

    logic [31:0] rem_reg [DIV_STEPS+1];
    logic [31:0] lo_reg  [DIV_STEPS+1];
    logic [31:0] q_reg   [DIV_STEPS+1];
    logic [31:0] d_reg   [DIV_STEPS+1];
    logic        neg_reg [DIV_STEPS+1];
    logic        ovf_reg [DIV_STEPS+1];
    logic signed [31:0] quot_reg;
    logic signed [31:0] quot_next;

    logic [31:0]   mag_n;
    logic [31:0]   mag_d;
    logic [DW-1:0] dividend;

    assign mag_n    = num[31] ? 32'(-num) : 32'(num);
    assign mag_d    = den[31] ? 32'(-den) : 32'(den);
    assign dividend = {mag_n, {FRAC_BITS{1'b0}}};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= 32'(dividend[DW-1:32]);
            lo_reg[0]  <= dividend[31:0];
            q_reg[0]   <= '0;
            d_reg[0]   <= mag_d;
            neg_reg[0] <= num[31] ^ den[31];
            // quotient of 2^32 or more always saturates
            ovf_reg[0] <= 64'(dividend) >= {mag_d, 32'd0};
            quot_reg   <= quot_next;
        end
    end

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_step
        logic [32:0] t;
        logic        ge;
        assign t  = {rem_reg[k], lo_reg[k][31]};
        assign ge = t >= {1'b0, d_reg[k]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= ge ? 32'(t - {1'b0, d_reg[k]}) : t[31:0];
                lo_reg[k+1]  <= {lo_reg[k][30:0], 1'b0};
                q_reg[k+1]   <= {q_reg[k][30:0], ge};
                d_reg[k+1]   <= d_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
            end
        end
    end

    always_comb
    begin
        logic [31:0] q;
        q = q_reg[DIV_STEPS];
        if (!neg_reg[DIV_STEPS])
            quot_next = (ovf_reg[DIV_STEPS] || q[31]) ? 32'sh7FFF_FFFF : $signed(q);
        else if (ovf_reg[DIV_STEPS] || (q > 32'h8000_0000))
            quot_next = 32'sh8000_0000;
        else
            quot_next = $signed(32'(-q));
    end

    assign quot = quot_reg;

endmodule

// File: tb/vertex_project_to_viewport_core_tb.sv
// ----------------------------------------------------------------------------
// vertex_project_to_viewport_core_tb
// self-checking bench for the matrix, perspective divide and viewport mapping
// ----------------------------------------------------------------------------
// Matrix coefficients and vertices are sent over the input channel, and the
// viewport registers are written over the APB port. A predictor inside the
// bench works out every window position. Each result is checked against the
// oldest expected one, in order.
module vertex_project_to_viewport_core_tb;
    import vpv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = 16;

    typedef struct packed {
        logic signed [31:0] wx;
        logic signed [31:0] wy;
        logic signed [31:0] dz;
        logic               wn;
    } window_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;
    logic in_valid;
    logic in_ready;
    logic req_type;
    logic [3:0] coef_index;
    logic signed [31:0] coef_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic out_valid;
    logic out_ready;
    logic signed [31:0] window_x;
    logic signed [31:0] window_y;
    logic signed [31:0] depth_z;
    logic w_was_null;

    // bench copy of the block state
    logic signed [31:0] mat [16];
    logic signed [15:0] vp_x;
    logic signed [15:0] vp_y;
    logic [14:0] vp_w;
    logic [14:0] vp_h;

    window_t expected_windows[$];
    int errors;
    int vertices_sent;
    int loads_sent;
    int windows_seen;
    int hold_off;
    bit rx_random;

    vertex_project_to_viewport_core u_top (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic window_t project_point(input logic signed [31:0] px,
                                              input logic signed [31:0] py,
                                              input logic signed [31:0] pz);
        logic signed [63:0] pt [3];
        logic signed [63:0] clip [4];
        logic signed [63:0] acc;
        logic signed [63:0] w;
        logic signed [63:0] n;
        logic signed [63:0] m [3];
        logic signed [63:0] one;
        window_t r;
        one = 64'sd1 <<< FB;
        pt[0] = px;
        pt[1] = py;
        pt[2] = pz;
        for (int row = 0; row < 4; row++)
        begin
            acc = mat[row*4+3];
            for (int col = 0; col < 3; col++)
                acc = acc + ((64'(mat[row*4+col]) * pt[col]) >>> FB);
            clip[row] = clamp32(acc);
        end
        w = clip[3];
        r.wn = (w == 0);
        if (w == 0)
            w = one;
        for (int row = 0; row < 3; row++)
        begin
            n = clamp32((clip[row] * one) / w);
            m[row] = (n >>> 1) + (64'sd1 <<< (FB - 1));
        end
        r.wx = 32'(clamp32(m[0] * $signed({1'b0, vp_w}) + (64'(vp_x) <<< FB)));
        r.wy = 32'(clamp32(m[1] * $signed({1'b0, vp_h}) + (64'(vp_y) <<< FB)));
        r.dz = 32'(clamp32(m[2]));
        return r;
    endfunction

    task automatic send_item(input req_t kind, input logic [3:0] idx,
                             input logic signed [31:0] cv, input logic signed [31:0] px,
                             input logic signed [31:0] py, input logic signed [31:0] pz,
                             input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 19) : 0;
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= kind;
        coef_index <= idx;
        coef_value <= cv;
        point_x <= px;
        point_y <= py;
        point_z <= pz;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (kind == REQ_LOAD)
        begin
            mat[idx] = cv;
            loads_sent++;
        end
        else
        begin
            expected_windows.push_back(project_point(px, py, pz));
            vertices_sent++;
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_windows.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(idx) << 2;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_VP_X: vp_x = value[15:0];
            REG_VP_Y: vp_y = value[15:0];
            REG_VP_W: vp_w = value[14:0];
            REG_VP_H: vp_h = value[14:0];
            default:  ;
        endcase
    endtask

    task automatic set_viewport(input logic [31:0] x, input logic [31:0] y,
                                input logic [31:0] w, input logic [31:0] h);
        drain();
        write_reg(REG_VP_X, x);
        write_reg(REG_VP_Y, y);
        write_reg(REG_VP_W, w);
        write_reg(REG_VP_H, h);
    endtask

    function automatic logic signed [31:0] rand_coef();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'sh0001_0000;
            2: return 32'(int'($urandom_range(0, 262143)) - 131072);
            3: return 32'(int'($urandom_range(0, 4095)) - 2048);
            4: return 32'sh0;
            default: return 32'(int'($urandom_range(0, 8388607)) - 4194304);
        endcase
    endfunction

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return 32'(int'($urandom_range(0, 2097151)) - 1048576);
            2: return 32'sh7FFF_FFFF;
            3: return 32'(int'($urandom_range(0, 131071)) - 65536);
            default: return 32'(int'($urandom_range(0, 33554431)) - 16777216);
        endcase
    endfunction

    task automatic load_matrix(input bit identity_like, input bit gaps);
        for (int i = 0; i < 16; i++)
        begin
            if (identity_like)
                send_item(REQ_LOAD, 4'(i), (i % 5 == 0) ? 32'sh0001_0000 : 32'sh0,
                          $urandom, $urandom, $urandom, gaps);
            else
                send_item(REQ_LOAD, 4'(i), rand_coef(), $urandom, $urandom, $urandom, gaps);
        end
    endtask

    // extremes, null w and zero viewport
    task automatic test_directed();
        send_item(REQ_VERTEX, 4'hF, 32'sh7FFF_FFFF, 32'sh0001_0000, 32'sh0, 32'sh0, 0);
        load_matrix(1, 0);
        send_item(REQ_VERTEX, 4'h0, 32'sh0, 32'sh0000_8000, -32'sh0000_8000, 32'sh0, 0);
        send_item(REQ_VERTEX, 4'h0, 32'sh0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 0);
        set_viewport(32'h0000_7FFF, 32'h0000_8000, 32'h7FFF, 32'h7FFF);
        send_item(REQ_VERTEX, 4'h0, 32'sh0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 0);
        send_item(REQ_VERTEX, 4'h0, 32'sh0, 32'sh0001_0000, 32'sh0002_0000, 32'sh0, 0);
        // clip w forced to zero
        send_item(REQ_LOAD, 4'd15, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 0);
        send_item(REQ_VERTEX, 4'h0, 32'sh0, 32'sh0003_0000, 32'sh0, 32'sh0, 0);
        send_item(REQ_LOAD, 4'd12, 32'sh7FFF_FFFF, 32'sh0, 32'sh0, 32'sh0, 0);
        send_item(REQ_LOAD, 4'd15, 32'sh8000_0000, 32'sh0, 32'sh0, 32'sh0, 0);
        send_item(REQ_VERTEX, 4'h0, 32'sh0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh1, 0);
        send_item(REQ_VERTEX, 4'h0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 0);
        set_viewport(32'hFFFF_8000, 32'h0000_7FFF, 32'h0, 32'h0);
        send_item(REQ_VERTEX, 4'h0, 32'sh0, 32'sh0001_0000, 32'sh0, 32'sh0, 0);
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 199) == 0)
                load_matrix(0, 1);
            else if ($urandom_range(0, 15) == 0)
                send_item(REQ_LOAD, 4'($urandom), rand_coef(), $urandom, $urandom,
                          $urandom, 1);
            else
                send_item(REQ_VERTEX, 4'($urandom), $urandom, rand_coord(), rand_coord(),
                          rand_coord(), (i / 100) % 3 != 0);
        end
    endtask

    // receiver stops long enough for the pipe to fill and hold its input
    task automatic test_backpressure();
        rx_random = 0;
        hold_off = 200;
        for (int i = 0; i < 80; i++)
            send_item(REQ_VERTEX, 4'h0, 32'sh0, rand_coord(), rand_coord(), rand_coord(), 0);
        rx_random = 1;
        drain();
    endtask

    initial
    begin
        errors = 0;
        vertices_sent = 0;
        loads_sent = 0;
        windows_seen = 0;
        hold_off = 0;
        rx_random = 1;
        for (int i = 0; i < 16; i++)
            mat[i] = '0;
        vp_x = '0;
        vp_y = '0;
        vp_w = '0;
        vp_h = '0;
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        req_type = REQ_VERTEX;
        coef_index = '0;
        coef_value = '0;
        point_x = '0;
        point_y = '0;
        point_z = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        set_viewport(32'h0000_0010, 32'hFFFF_FFF0, 32'h0280, 32'h01E0);
        load_matrix(0, 0);
        test_random(600);
        test_backpressure();
        set_viewport($urandom, $urandom, $urandom_range(0, 32767), $urandom_range(0, 32767));
        test_random(600);
        set_viewport(32'h0000_7FFF, 32'h0000_7FFF, 32'h7FFF, 32'h7FFF);
        test_random(600);
        drain();
        $display("covered %0d vertices and %0d coefficient loads over 5 viewport settings",
                 vertices_sent, loads_sent);
        $display("%0d window results checked, including stalls and null w", windows_seen);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // receiver stalls
    initial
    begin
        int wait_n;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_off) @(posedge clk);
                hold_off = 0;
            end
            wait_n = rx_random ? $urandom_range(0, 19) : 0;
            if ($urandom_range(0, 2) == 0)
                wait_n = 0;
            if (wait_n > 0)
            begin
                out_ready <= 1'b0;
                repeat (wait_n) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        window_t e;
        if (rst_n && out_valid && out_ready)
        begin
            windows_seen++;
            if (expected_windows.size() == 0)
            begin
                $error("unexpected window transfer");
                errors++;
            end
            else
            begin
                e = expected_windows.pop_front();
                if (window_x !== e.wx)
                begin
                    $error("window_x: expected %0d, actual %0d", e.wx, window_x);
                    errors++;
                end
                if (window_y !== e.wy)
                begin
                    $error("window_y: expected %0d, actual %0d", e.wy, window_y);
                    errors++;
                end
                if (depth_z !== e.dz)
                begin
                    $error("depth_z: expected %0d, actual %0d", e.dz, depth_z);
                    errors++;
                end
                if (w_was_null !== e.wn)
                begin
                    $error("w_was_null: expected %0b, actual %0b", e.wn, w_was_null);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #10ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
